/* rtl/h2fh_pkg.sv */
// ----------------------------------------------------------------------------
// h2fh_pkg
// Shared types and codes of the HTTP/2 frame header checker.
// ----------------------------------------------------------------------------
package h2fh_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Header status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  // Frame types with fixed rules
  localparam logic [7:0] T_PRIORITY      = 8'h02;
  localparam logic [7:0] T_RST_STREAM    = 8'h03;
  localparam logic [7:0] T_SETTINGS      = 8'h04;
  localparam logic [7:0] T_PING          = 8'h06;
  localparam logic [7:0] T_GOAWAY        = 8'h07;
  localparam logic [7:0] T_WINDOW_UPDATE = 8'h08;

  localparam logic [7:0] ACK_FLAG  = 8'h01;
  localparam logic [3:0] HDR_LAST  = 4'd8;   // position of the ninth header byte

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] stream_ident;
    logic        settings_valid;
    logic        settings_ack;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  // One queue entry: what a single accepted byte causes
  typedef struct packed {
    result_t main;
    logic    has_main;
    logic    trunc;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

/* rtl/h2fh_rx_if.sv */
// ----------------------------------------------------------------------------
// h2fh_rx_if
// Byte request channel into the frame header checker.
// ----------------------------------------------------------------------------
interface h2fh_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, rx_byte, buffer_end, input ready);
  modport sink   (input valid, rx_byte, buffer_end, output ready);
endinterface

/* rtl/h2fh_tx_if.sv */
// ----------------------------------------------------------------------------
// h2fh_tx_if
// Result request channel out of the frame header checker.
// ----------------------------------------------------------------------------
interface h2fh_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  status;
  logic [23:0] frame_length;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] stream_ident;
  logic        settings_valid;
  logic        settings_ack;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, result_kind, status, frame_length, frame_type,
                  frame_flags, stream_ident, settings_valid, settings_ack,
                  payload_byte, last, input ready);
  modport sink   (input valid, result_kind, status, frame_length, frame_type,
                  frame_flags, stream_ident, settings_valid, settings_ack,
                  payload_byte, last, output ready);
endinterface

/* rtl/http2_frame_header_check_core.sv */
// ----------------------------------------------------------------------------
// http2_frame_header_check_core
// Byte-serial HTTP/2 frame header checker with payload pass-through.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. Every byte is parsed in the cycle it is accepted;
// each frame gives a header result on its ninth byte (status, header fields,
// SETTINGS flags), then its payload bytes one per cycle when the status is ok,
// or nothing when the frame is bad. A buffer that ends inside a frame adds a
// truncation result, so one byte may cause two results; the output register
// sends them one after the other and the queue soaks up the delay. An
// accepted byte's result is written into a queue slot and then loaded into
// the output register. Input ready falls only when the QUEUE_DEPTH-entry
// queue between parser and output register is full, so the block sustains
// one byte per cycle as long as the consumer takes one result per cycle.
// ----------------------------------------------------------------------------
module http2_frame_header_check_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic         clk,
  input logic         rst,
  h2fh_rx_if.sink     rx,
  h2fh_tx_if.source   tx
);

  logic                  push;
  logic                  pop;
  h2fh_pkg::entry_t      wr_entry;
  h2fh_pkg::entry_t      head;
  h2fh_pkg::queue_stat_t q_stat;

  // Parse bytes and classify them into queue entries
  h2fh_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .full  (q_stat.full),
    .push  (push),
    .entry (wr_entry)
  );

  // Decouple parsing from output stalls
  h2fh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Issue main and truncation results through the output register
  h2fh_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_stat.empty),
    .pop   (pop),
    .tx    (tx)
  );

  // A truncation request always closes the frame with the truncated status
  a_trunc_closes: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.result_kind == h2fh_pkg::KIND_TRUNC)
      |-> (tx.status == h2fh_pkg::ST_TRUNC && tx.last))
    else $error("truncation request without truncated status or last mark");

  // Payload requests carry the ok status and no header length
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.result_kind == h2fh_pkg::KIND_PAY)
      |-> (tx.status == h2fh_pkg::ST_OK && tx.frame_length == '0))
    else $error("payload request carries header fields");

  // No request of an unknown kind leaves the block
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.result_kind == h2fh_pkg::KIND_HDR ||
                  tx.result_kind == h2fh_pkg::KIND_PAY ||
                  tx.result_kind == h2fh_pkg::KIND_TRUNC))
    else $error("request of unknown kind");

  // A queue entry is never popped while the queue is empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

/* rtl/h2fh_front.sv */
// ----------------------------------------------------------------------------
// h2fh_front
// Byte parser: collects the header, checks it, tracks payload, flags truncation.
// ----------------------------------------------------------------------------
module h2fh_front (
  input  logic                clk,
  input  logic                rst,
  h2fh_rx_if.sink             rx,
  input  logic                full,
  output logic                push,
  output h2fh_pkg::entry_t    entry
);

  logic [3:0]  header_position, header_position_next;
  logic [23:0] held_length, held_length_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [31:0] held_stream, held_stream_next;
  logic [1:0]  len_mod3, len_mod3_next;
  logic [23:0] payload_left, payload_left_next;
  logic        drop_payload, drop_payload_next;

  logic        accept;
  logic        has_main;
  logic        trunc;
  h2fh_pkg::result_t res;

  // residue mod 3 of running value times 256 plus byte (256 is 1 mod 3)
  function automatic logic [1:0] fold_mod3(input logic [1:0] r, input logic [7:0] b);
    logic [3:0] v;
    v = {2'b00, r} + {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]}
        + {2'b00, b[7:6]};
    for (int i = 0; i < 4; i++) begin
      if (v >= 4'd3) v = v - 4'd3;
    end
    return v[1:0];
  endfunction

  function automatic logic needs_zero_id(input logic [7:0] t);
    return (t == h2fh_pkg::T_SETTINGS) || (t == h2fh_pkg::T_PING) ||
           (t == h2fh_pkg::T_GOAWAY)   || (t == h2fh_pkg::T_WINDOW_UPDATE);
  endfunction

  assign rx.ready = !full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    logic [23:0] left_dec;
    logic [31:0] sid;
    logic [1:0]  st;
    logic        is_set;
    logic        done;
    logic        hdr_trunc;

    header_position_next = header_position;
    held_length_next     = held_length;
    held_type_next       = held_type;
    held_flags_next      = held_flags;
    held_stream_next     = held_stream;
    len_mod3_next        = len_mod3;
    payload_left_next    = payload_left;
    drop_payload_next    = drop_payload;
    has_main             = 1'b0;
    res                  = '0;
    left_dec             = payload_left - 24'd1;
    sid                  = {held_stream[23:0], rx.rx_byte};
    st                   = h2fh_pkg::ST_OK;
    is_set               = 1'b0;
    done                 = 1'b0;
    hdr_trunc            = 1'b0;

    if (payload_left != '0) begin
      // payload byte: pass or drop
      payload_left_next = left_dec;
      if (!drop_payload) begin
        has_main         = 1'b1;
        res.result_kind  = h2fh_pkg::KIND_PAY;
        res.payload_byte = rx.rx_byte;
        res.last         = (left_dec == '0);
      end
      if (left_dec == '0) drop_payload_next = 1'b0;
    end else begin
      priority if (header_position < 4'd3) begin
        held_length_next = {held_length[15:0], rx.rx_byte};
        len_mod3_next    = fold_mod3((header_position == '0) ? 2'd0 : len_mod3,
                                     rx.rx_byte);
      end else if (header_position == 4'd3) begin
        held_type_next = rx.rx_byte;
      end else if (header_position == 4'd4) begin
        held_flags_next = rx.rx_byte;
      end else begin
        held_stream_next = sid;
      end

      if (header_position == h2fh_pkg::HDR_LAST) begin
        // size check first, then the stream id rule
        if ((held_type == h2fh_pkg::T_PRIORITY      && held_length != 24'd5) ||
            (held_type == h2fh_pkg::T_RST_STREAM    && held_length != 24'd4) ||
            (held_type == h2fh_pkg::T_PING          && held_length != 24'd8) ||
            (held_type == h2fh_pkg::T_WINDOW_UPDATE && held_length != 24'd4))
          st = h2fh_pkg::ST_BAD_SIZE;
        else if ((sid != '0) == needs_zero_id(held_type))
          st = h2fh_pkg::ST_BAD_ID;
        is_set    = (held_type == h2fh_pkg::T_SETTINGS);
        done      = (held_length == '0) || (st != h2fh_pkg::ST_OK);
        hdr_trunc = rx.buffer_end && (held_length != '0);

        has_main           = 1'b1;
        res.result_kind    = h2fh_pkg::KIND_HDR;
        res.status         = st;
        res.frame_length   = held_length;
        res.frame_type     = held_type;
        res.frame_flags    = held_flags;
        res.stream_ident   = sid;
        res.settings_ack   = is_set && (held_flags == h2fh_pkg::ACK_FLAG);
        res.settings_valid = is_set && (len_mod3 == 2'd0) && !held_length[0] &&
                             !((held_length != '0) && (held_flags == h2fh_pkg::ACK_FLAG));
        res.last           = done && !hdr_trunc;

        header_position_next = '0;
        payload_left_next    = held_length;
        drop_payload_next    = (st != h2fh_pkg::ST_OK);
      end else begin
        header_position_next = header_position + 4'd1;
      end
    end

    // buffer ends inside a frame: report and go idle
    trunc = rx.buffer_end && ((header_position_next != '0) || (payload_left_next != '0));
    if (trunc) begin
      header_position_next = '0;
      payload_left_next    = '0;
      drop_payload_next    = 1'b0;
    end
  end

  assign push           = accept && (has_main || trunc);
  assign entry.main     = res;
  assign entry.has_main = has_main;
  assign entry.trunc    = trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      payload_left    <= '0;
      drop_payload    <= 1'b0;
    end else if (accept) begin
      header_position <= header_position_next;
      payload_left    <= payload_left_next;
      drop_payload    <= drop_payload_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_length <= held_length_next;
      held_type   <= held_type_next;
      held_flags  <= held_flags_next;
      held_stream <= held_stream_next;
      len_mod3    <= len_mod3_next;
    end
  end

endmodule

/* rtl/h2fh_queue.sv */
// ----------------------------------------------------------------------------
// h2fh_queue
// Register queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module h2fh_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  h2fh_pkg::entry_t        wr_entry,
  input  logic                    pop,
  output h2fh_pkg::entry_t        head,
  output h2fh_pkg::queue_stat_t   stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  h2fh_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_MAX);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/h2fh_back.sv */
// ----------------------------------------------------------------------------
// h2fh_back
// Result sequencer: turns queue entries into one or two results.
// ----------------------------------------------------------------------------
module h2fh_back (
  input  logic                    clk,
  input  logic                    rst,
  input  h2fh_pkg::entry_t        head,
  input  logic                    empty,
  output logic                    pop,
  h2fh_tx_if.source               tx
);

  h2fh_pkg::result_t out_res;
  h2fh_pkg::result_t trunc_res;
  logic              out_valid;
  logic              second;      // main result of head already sent
  logic              can_load;
  logic              take_main;

  always_comb begin
    trunc_res             = '0;
    trunc_res.result_kind = h2fh_pkg::KIND_TRUNC;
    trunc_res.status      = h2fh_pkg::ST_TRUNC;
    trunc_res.last        = 1'b1;
  end

  assign can_load  = !out_valid || tx.ready;
  assign take_main = head.has_main && !second;
  // advance past the entry once its final result is loaded
  assign pop       = !empty && can_load && !(take_main && head.trunc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (!empty && can_load) begin
      out_valid <= 1'b1;
      second    <= take_main && head.trunc;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!empty && can_load) out_res <= take_main ? head.main : trunc_res;
  end

  assign tx.valid          = out_valid;
  assign tx.result_kind    = out_res.result_kind;
  assign tx.status         = out_res.status;
  assign tx.frame_length   = out_res.frame_length;
  assign tx.frame_type     = out_res.frame_type;
  assign tx.frame_flags    = out_res.frame_flags;
  assign tx.stream_ident   = out_res.stream_ident;
  assign tx.settings_valid = out_res.settings_valid;
  assign tx.settings_ack   = out_res.settings_ack;
  assign tx.payload_byte   = out_res.payload_byte;
  assign tx.last           = out_res.last;

endmodule

/* bench/tb_http2_frame_header_check_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http2_frame_header_check_core
// Self-checking bench for the byte-serial HTTP/2 frame header checker.
// ----------------------------------------------------------------------------
// Feeds the block a stream of frames one byte per request: a few hand-built
// frames first, then random frames of every type with mostly legal sizes and
// identifiers, some bad ones, cut buffers, oversized lengths and bursts of
// line noise. A scoreboard mirrors the parser byte by byte, queues the header,
// payload and truncation results each byte should cause, and checks every
// result request leaving the block against the oldest one queued.
// Both sides idle at random, with one stretch where neither does; the result
// side also holds off once for a long time so the internal queue fills and
// input ready drops, and the byte side once waits until the block has drained.
// ----------------------------------------------------------------------------
module tb_http2_frame_header_check_core;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_BYTES   = 800;
  localparam int OPENING_BYTES  = 24;
  localparam int IDLE_PERCENT   = 35;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_AT        = 250;
  localparam int DRAIN_AT       = 450;
  localparam int CALM_FROM      = 600;
  localparam int CALM_TO        = 760;

  // Fixed payload sizes and SETTINGS entry size
  localparam int LEN_PRIORITY      = 5;
  localparam int LEN_RST_STREAM    = 4;
  localparam int LEN_PING          = 8;
  localparam int LEN_WINDOW_UPDATE = 4;
  localparam int SETTINGS_ENTRY    = 6;

  // Header byte positions: length occupies the first three
  localparam logic [3:0] POS_TYPE  = 4'd3;
  localparam logic [3:0] POS_FLAGS = 4'd4;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the parser and holds the results still owed
  // --------------------------------------------------------------------------
  class frame_result_tracker;
    logic [3:0]         header_position;
    logic [23:0]        held_length;
    logic [7:0]         held_type;
    logic [7:0]         held_flags;
    logic [31:0]        held_stream;
    logic [23:0]        payload_left;
    logic               drop_payload;
    h2fh_pkg::result_t  expected_results [$];
    int                 mismatch_count;

    function new();
      header_position = '0;
      held_length     = '0;
      held_type       = '0;
      held_flags      = '0;
      held_stream     = '0;
      payload_left    = '0;
      drop_payload    = 1'b0;
      mismatch_count  = 0;
    endfunction

    // Size rule first, then the identifier rule
    function logic [1:0] header_status();
      logic zero_id_type;
      zero_id_type = (held_type == h2fh_pkg::T_SETTINGS) ||
                     (held_type == h2fh_pkg::T_PING) ||
                     (held_type == h2fh_pkg::T_GOAWAY) ||
                     (held_type == h2fh_pkg::T_WINDOW_UPDATE);
      if ((held_type == h2fh_pkg::T_PRIORITY && held_length != LEN_PRIORITY) ||
          (held_type == h2fh_pkg::T_RST_STREAM && held_length != LEN_RST_STREAM) ||
          (held_type == h2fh_pkg::T_PING && held_length != LEN_PING) ||
          (held_type == h2fh_pkg::T_WINDOW_UPDATE &&
           held_length != LEN_WINDOW_UPDATE))
        return h2fh_pkg::ST_BAD_SIZE;
      if ((held_stream != '0) == zero_id_type)
        return h2fh_pkg::ST_BAD_ID;
      return h2fh_pkg::ST_OK;
    endfunction

    // Work out what one accepted byte causes and queue it
    function void note_byte(logic [7:0] rx_val, logic at_end);
      h2fh_pkg::result_t outs [2];
      h2fh_pkg::result_t r;
      int                n;
      logic [3:0]        pos;
      logic [1:0]        st;
      n = 0;
      if (payload_left != '0) begin
        payload_left = payload_left - 24'd1;
        if (!drop_payload) begin
          r = '0;
          r.result_kind  = h2fh_pkg::KIND_PAY;
          r.payload_byte = rx_val;
          r.last         = (payload_left == '0);
          outs[n] = r;
          n++;
        end
        if (payload_left == '0) drop_payload = 1'b0;
      end else begin
        pos = header_position;
        if (pos < POS_TYPE) held_length = {held_length[15:0], rx_val};
        else if (pos == POS_TYPE) held_type = rx_val;
        else if (pos == POS_FLAGS) held_flags = rx_val;
        else held_stream = {held_stream[23:0], rx_val};
        if (pos == h2fh_pkg::HDR_LAST) begin
          st = header_status();
          r = '0;
          r.result_kind    = h2fh_pkg::KIND_HDR;
          r.status         = st;
          r.frame_length   = held_length;
          r.frame_type     = held_type;
          r.frame_flags    = held_flags;
          r.stream_ident   = held_stream;
          r.settings_ack   = (held_type == h2fh_pkg::T_SETTINGS) &&
                             (held_flags == h2fh_pkg::ACK_FLAG);
          r.settings_valid = (held_type == h2fh_pkg::T_SETTINGS) &&
                             (held_length % SETTINGS_ENTRY == 0) &&
                             !(held_length != '0 && held_flags == h2fh_pkg::ACK_FLAG);
          r.last           = (held_length == '0 || st != h2fh_pkg::ST_OK) &&
                             !(at_end && held_length != '0);
          outs[n] = r;
          n++;
          header_position = '0;
          payload_left    = held_length;
          drop_payload    = (st != h2fh_pkg::ST_OK);
        end else begin
          header_position = pos + 4'd1;
        end
      end
      // Buffer ends part-way through a frame: add the truncation result
      if (at_end && (header_position != '0 || payload_left != '0)) begin
        if (n > 0 && outs[n-1].result_kind == h2fh_pkg::KIND_PAY) outs[n-1].last = 1'b0;
        r = '0;
        r.result_kind = h2fh_pkg::KIND_TRUNC;
        r.status      = h2fh_pkg::ST_TRUNC;
        r.last        = 1'b1;
        outs[n] = r;
        n++;
        header_position = '0;
        payload_left    = '0;
        drop_payload    = 1'b0;
      end
      for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%s mismatch: expected %0h, actual %0h", field, want, seen);
      end
    endfunction

    function void check_result(h2fh_pkg::result_t seen);
      h2fh_pkg::result_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result with nothing expected: kind %0d, status %0d",
                   seen.result_kind, seen.status);
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_kind", want.result_kind, seen.result_kind);
      compare_field("status", want.status, seen.status);
      compare_field("frame_length", want.frame_length, seen.frame_length);
      compare_field("frame_type", want.frame_type, seen.frame_type);
      compare_field("frame_flags", want.frame_flags, seen.frame_flags);
      compare_field("stream_ident", want.stream_ident, seen.stream_ident);
      compare_field("settings_valid", want.settings_valid, seen.settings_valid);
      compare_field("settings_ack", want.settings_ack, seen.settings_ack);
      compare_field("payload_byte", want.payload_byte, seen.payload_byte);
      compare_field("last", want.last, seen.last);
    endfunction

    // Anything still owed at the end counts against the run
    function void close_out();
      if (expected_results.size() != 0) begin
        mismatch_count++;
        $display("%0d expected results never arrived", expected_results.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  h2fh_rx_if rx_ch();
  h2fh_tx_if tx_ch();

  http2_frame_header_check_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  frame_result_tracker sb;
  int   sent_count   = 0;
  int   cycle_count  = 0;
  logic calm         = 1'b0;   // both sides stop idling while set
  logic hold_request = 1'b0;   // asks the result side for one long hold-off

  // Directed opening, {buffer_end, byte}:
  //   a DATA frame with every flag set, the reserved identifier bit and a
  //   one-byte payload; a bare SETTINGS ACK whose last byte ends the buffer
  //   exactly on the frame boundary; a header cut off after its flags byte
  //   with the largest possible length.
  logic [8:0] opening [OPENING_BYTES] = '{
    9'h000, 9'h000, 9'h001, 9'h000, 9'h0FF, 9'h080, 9'h000, 9'h000, 9'h001,
    9'h0FF,
    9'h000, 9'h000, 9'h000, 9'h004, 9'h001, 9'h000, 9'h000, 9'h000, 9'h100,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h008, 9'h100
  };

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  // Enter and leave on a falling edge. Idle at random first, then offer the
  // byte and hold it until a rising edge sees valid and ready together.
  task automatic send_byte(input logic [7:0] rx_val, input logic at_end);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid      <= 1'b1;
    rx_ch.rx_byte    <= rx_val;
    rx_ch.buffer_end <= at_end;
    @(posedge clk);
    while (rx_ch.ready !== 1'b1) @(posedge clk);
    sb.note_byte(rx_val, at_end);
    sent_count++;
    calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has left the block
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // One frame with random content, sometimes cut short
  task automatic send_frame();
    logic [7:0]  ftype;
    logic [7:0]  fflags;
    logic [23:0] flen;
    logic [31:0] fsid;
    logic [7:0]  hdr [9];
    logic        oversized;
    logic        end_on_boundary;
    int          total;
    int          cut;
    int          stop_at;
    case ($urandom_range(0, 9))
      6:       ftype = 8'($urandom_range(0, 255));
      7:       ftype = h2fh_pkg::T_SETTINGS;
      8:       ftype = h2fh_pkg::T_PING;
      9:       ftype = h2fh_pkg::T_WINDOW_UPDATE;
      default: ftype = 8'($urandom_range(0, 9));
    endcase
    // Mostly the size the type demands, sometimes any size up to 90
    case (ftype)
      h2fh_pkg::T_PRIORITY:      flen = 24'(LEN_PRIORITY);
      h2fh_pkg::T_RST_STREAM:    flen = 24'(LEN_RST_STREAM);
      h2fh_pkg::T_WINDOW_UPDATE: flen = 24'(LEN_WINDOW_UPDATE);
      h2fh_pkg::T_PING:          flen = 24'(LEN_PING);
      h2fh_pkg::T_SETTINGS:      flen = 24'(SETTINGS_ENTRY * $urandom_range(0, 3));
      default:                   flen = 24'($urandom_range(0, 12));
    endcase
    if ($urandom_range(0, 4) == 0) flen = 24'($urandom_range(0, 12));
    if ($urandom_range(0, 19) == 0) flen = 24'($urandom_range(13, 90));
    // Oversized lengths are always cut a few bytes into the payload
    oversized = ($urandom_range(0, 39) == 0);
    if (oversized)
      flen = $urandom_range(0, 1) ? 24'hFF_FFFF : (24'($urandom()) | 24'h80_0000);
    case ($urandom_range(0, 9))
      0, 1, 2: fflags = h2fh_pkg::ACK_FLAG;
      3:       fflags = '0;
      default: fflags = 8'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: fsid = '0;
      4:          fsid = 32'hFFFF_FFFF;
      5:          fsid = 32'h8000_0000;
      default:    fsid = $urandom();
    endcase
    hdr = '{flen[23:16], flen[15:8], flen[7:0], ftype, fflags,
            fsid[31:24], fsid[23:16], fsid[15:8], fsid[7:0]};
    if (oversized) begin
      total = 0;
      cut   = 9 + $urandom_range(0, 4);
    end else begin
      total = 9 + int'(flen);
      cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 2) : -1;
    end
    end_on_boundary = (cut < 0) && ($urandom_range(0, 4) == 0);
    stop_at = (cut >= 0) ? cut : total - 1;
    for (int i = 0; i <= stop_at; i++)
      send_byte((i < 9) ? hdr[i] : 8'($urandom()),
                (i == cut) || (end_on_boundary && i == total - 1));
  endtask

  // Line noise: random bytes, random buffer ends, always closed by one
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom()), (i == n - 1) || ($urandom_range(0, 7) == 0));
  endtask

  initial begin
    logic hold_done;
    logic drain_done;
    hold_done        = 1'b0;
    drain_done       = 1'b0;
    sb               = new();
    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    rx_ch.buffer_end = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_BYTES; i++)
      send_byte(opening[i][7:0], opening[i][8]);

    // Random part: mostly frames, a little noise. Start the long result
    // hold-off and the full drain between frames once their turn comes.
    while (sent_count < OPENING_BYTES + RANDOM_BYTES) begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && sent_count >= DRAIN_AT) begin
        drain_results();
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) send_noise();
      else send_frame();
    end

    // Wind down: wait for the last results, then a few quiet cycles
    rx_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // Change ready on the falling edge; count the long hold-off here.
  initial begin
    int hold_left;
    hold_left   = 0;
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        tx_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        tx_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Sample every accepted result on the rising edge and check it
  always @(posedge clk) begin
    h2fh_pkg::result_t seen;
    if (!rst && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) begin
      seen.result_kind    = tx_ch.result_kind;
      seen.status         = tx_ch.status;
      seen.frame_length   = tx_ch.frame_length;
      seen.frame_type     = tx_ch.frame_type;
      seen.frame_flags    = tx_ch.frame_flags;
      seen.stream_ident   = tx_ch.stream_ident;
      seen.settings_valid = tx_ch.settings_valid;
      seen.settings_ack   = tx_ch.settings_ack;
      seen.payload_byte   = tx_ch.payload_byte;
      seen.last           = tx_ch.last;
      sb.check_result(seen);
    end
  end

  // Watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

/* http2_frame_header_check_core.f */
rtl/h2fh_pkg.sv
rtl/h2fh_rx_if.sv
rtl/h2fh_tx_if.sv
rtl/h2fh_front.sv
rtl/h2fh_queue.sv
rtl/h2fh_back.sv
rtl/http2_frame_header_check_core.sv
bench/tb_http2_frame_header_check_core.sv
